// ===== hw/rtl/scd_pkg.sv =====
// shared types and constants for the servo and motor command decoder
// no dependencies; imported by every module of the block
package scd_pkg;

    // ascii codes seen by the line parser
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_S     = 8'h53;

    // fixed motor presets, two's complement
    localparam logic [7:0] SPEED_FWD  = 8'h32;  // +50
    localparam logic [7:0] SPEED_REV  = 8'hCE;  // -50
    localparam logic [7:0] SPEED_STOP = 8'h00;

    localparam logic [7:0] ANGLE_MAX = 8'd180;

    // floor(x/d) = (x * ceil(2^31/d)) >> 31, exact for x < 2^23
    localparam int          RECIP_SHIFT  = 31;
    localparam logic [24:0] RECIP_DIV180 = 25'd11930465;
    localparam logic [24:0] RECIP_DIV100 = 25'd21474837;

    // configuration register map
    localparam logic [1:0] CFG_SERVO_MIN  = 2'd0;
    localparam logic [1:0] CFG_SERVO_SPAN = 2'd1;
    localparam logic [1:0] CFG_MOTOR_FULL = 2'd2;

    localparam logic [14:0] SERVO_MIN_RESET  = 15'd1000;
    localparam logic [14:0] SERVO_SPAN_RESET = 15'd1000;
    localparam logic [14:0] MOTOR_FULL_RESET = 15'd999;

    typedef enum logic [1:0] {
        KIND_SERVO   = 2'd0,
        KIND_MOTOR   = 2'd1,
        KIND_UNKNOWN = 2'd2
    } cmd_kind_t;

    // number parse phase, one-hot
    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } num_phase_t;

    // decoded line handed from the parser to the scaler
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;  // angle for servo, two's complement speed for motor
    } line_cmd_t;

    typedef struct packed {
        logic [14:0] servo_min;
        logic [14:0] servo_span;
        logic [14:0] motor_full;
    } cfg_regs_t;

endpackage

// ===== hw/rtl/servo_motor_command_decoder_core.sv =====
// top level of the servo and motor command decoder
// depends on scd_pkg, scd_line_parser and scd_cmd_scaler
//
// Takes one received text byte per transfer on the s_ channel, one per clock when
// the result side keeps up, and decodes text command lines. A CR or LF ends a
// non-empty line and produces one result transfer on the m_ channel: "S<n>" sets
// the servo (angle clamped to 180, compare = min + angle*span/180), "MF", "MR",
// "MS" and "M<n>" set the motor speed, sign and duty compare count, anything
// else reports an unrecognized line. Bytes past MAX_CHARS in a line are dropped
// and a NUL ends the text early. A result reaches the m_ ports through two
// registers: the 8x15 multiply against the configuration count runs in the
// transfer cycle into a pipeline register, and the reciprocal divide then runs
// from it into the result register once that register is free.
// Those two registers buffer results, so text bytes keep flowing while a result
// waits; bytes stall only when both hold an untaken result. Configuration
// registers are written through the cfg_ channel, which is always ready out of
// reset, and should only be changed while no line end is still in flight.
module servo_motor_command_decoder_core
    import scd_pkg::*;
#(
    parameter int MAX_CHARS = 15
) (
    input  logic              aclk,
    input  logic              aresetn,

    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [14:0]       cfg_data,

    // received text bytes
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_char,

    // decoded commands
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_cmd_kind,
    output logic [15:0]       m_servo_compare,
    output logic              m_motor_forward,
    output logic              m_motor_reverse,
    output logic [15:0]       m_motor_compare,
    output logic signed [8:0] m_requested_value
);

    cfg_regs_t cfg_reg, cfg_next;
    logic      in_accept;
    logic      cmd_valid;
    line_cmd_t cmd;
    logic      scaler_ready;

    // configuration writes never stall out of reset
    assign cfg_ready = aresetn;

    // register index decode, unused index ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SERVO_MIN:  cfg_next.servo_min  = cfg_data;
                CFG_SERVO_SPAN: cfg_next.servo_span = cfg_data;
                CFG_MOTOR_FULL: cfg_next.motor_full = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.servo_min  <= SERVO_MIN_RESET;
            cfg_reg.servo_span <= SERVO_SPAN_RESET;
            cfg_reg.motor_full <= MOTOR_FULL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // byte transfer happens whenever the scaler has room for a possible result
    assign s_ready   = scaler_ready && aresetn;
    assign in_accept = s_valid && s_ready;

    // line state and command decode
    scd_line_parser #(
        .MAX_CHARS (MAX_CHARS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_accept),
        .rx_char   (s_rx_char),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // compare count arithmetic and result register
    scd_cmd_scaler u_scaler (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cfg               (cfg_reg),
        .in_ready          (scaler_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cmd_kind        (m_cmd_kind),
        .m_servo_compare   (m_servo_compare),
        .m_motor_forward   (m_motor_forward),
        .m_motor_reverse   (m_motor_reverse),
        .m_motor_compare   (m_motor_compare),
        .m_requested_value (m_requested_value)
    );

endmodule

// ===== hw/rtl/scd_line_parser.sv =====
// per-byte line parser: keeps command letters and the running atoi value
// depends on scd_pkg
module scd_line_parser
    import scd_pkg::*;
#(
    parameter int MAX_CHARS = 15
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_char,
    output logic       cmd_valid,
    output line_cmd_t  cmd
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic [7:0]       first_char_reg, first_char_next;
    logic [7:0]       second_char_reg, second_char_next;
    logic             string_ended_reg, string_ended_next;
    num_phase_t       phase_reg, phase_next;
    logic             negative_reg, negative_next;
    logic [7:0]       accum_reg, accum_next;

    logic       line_end;
    logic       is_digit;
    logic       is_space;
    logic       is_sign;
    logic [7:0] accum_digit;
    num_phase_t phase_upd;
    logic       negative_upd;
    logic [7:0] accum_upd;
    logic [7:0] number_value;

    assign line_end = (rx_char == CHAR_LF) || (rx_char == CHAR_CR);
    assign is_digit = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
    assign is_space = (rx_char == CHAR_SPACE) || (rx_char == CHAR_TAB) ||
                      (rx_char == CHAR_VT) || (rx_char == CHAR_FF);
    assign is_sign  = (rx_char == CHAR_PLUS) || (rx_char == CHAR_MINUS);
    // accum*10 + digit, wrapped to 8 bits
    assign accum_digit = 8'({accum_reg, 3'b000} + {accum_reg, 1'b0}) +
                         (rx_char - CHAR_ZERO);

    // atoi step for one character
    always_comb begin
        phase_upd    = phase_reg;
        negative_upd = negative_reg;
        accum_upd    = accum_reg;
        unique case (phase_reg)
            PH_LEAD: begin
                if (is_space) begin
                    phase_upd = PH_LEAD;
                end else if (is_sign) begin
                    negative_upd = (rx_char == CHAR_MINUS);
                    phase_upd    = PH_SIGN;
                end else if (is_digit) begin
                    accum_upd = accum_digit;
                    phase_upd = PH_DIGITS;
                end else begin
                    phase_upd = PH_DONE;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (is_digit) begin
                    accum_upd = accum_digit;
                    phase_upd = PH_DIGITS;
                end else begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_upd = PH_DONE;
            end
            default: begin
                phase_upd = PH_DONE;
            end
        endcase
    end

    always_comb begin
        char_count_next   = char_count_reg;
        first_char_next   = first_char_reg;
        second_char_next  = second_char_reg;
        string_ended_next = string_ended_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        accum_next        = accum_reg;
        if (accept) begin
            if (line_end) begin
                char_count_next   = '0;
                first_char_next   = CHAR_NUL;
                second_char_next  = CHAR_NUL;
                string_ended_next = 1'b0;
                phase_next        = PH_LEAD;
                negative_next     = 1'b0;
                accum_next        = '0;
            end else if (char_count_reg < CNT_W'(MAX_CHARS)) begin
                if (!string_ended_reg) begin
                    if (char_count_reg == '0) begin
                        first_char_next = rx_char;
                    end else begin
                        if (char_count_reg == CNT_W'(1)) begin
                            second_char_next = rx_char;
                        end
                        if (rx_char != CHAR_NUL) begin
                            phase_next    = phase_upd;
                            negative_next = negative_upd;
                            accum_next    = accum_upd;
                        end
                    end
                    if (rx_char == CHAR_NUL) begin
                        string_ended_next = 1'b1;
                    end
                end
                char_count_next = char_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg   <= '0;
            first_char_reg   <= CHAR_NUL;
            second_char_reg  <= CHAR_NUL;
            string_ended_reg <= 1'b0;
            phase_reg        <= PH_LEAD;
            negative_reg     <= 1'b0;
            accum_reg        <= '0;
        end else begin
            char_count_reg   <= char_count_next;
            first_char_reg   <= first_char_next;
            second_char_reg  <= second_char_next;
            string_ended_reg <= string_ended_next;
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            accum_reg        <= accum_next;
        end
    end

    // line decode from the kept state
    assign number_value = negative_reg ? 8'(8'd0 - accum_reg) : accum_reg;
    assign cmd_valid    = accept && line_end && (char_count_reg != '0);

    always_comb begin
        cmd.value = number_value;
        if (first_char_reg == CHAR_S) begin
            cmd.kind = KIND_SERVO;
        end else if (first_char_reg == CHAR_M) begin
            cmd.kind = KIND_MOTOR;
            if (second_char_reg == CHAR_F) begin
                cmd.value = SPEED_FWD;
            end else if (second_char_reg == CHAR_R) begin
                cmd.value = SPEED_REV;
            end else if (second_char_reg == CHAR_S) begin
                cmd.value = SPEED_STOP;
            end
        end else begin
            cmd.kind = KIND_UNKNOWN;
        end
    end

endmodule

// ===== hw/rtl/scd_cmd_scaler.sv =====
// two-stage compare count scaler: multiply by config, then reciprocal divide
// depends on scd_pkg; holds the result register of the block
module scd_cmd_scaler
    import scd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  line_cmd_t         cmd,
    input  cfg_regs_t         cfg,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_cmd_kind,
    output logic [15:0]       m_servo_compare,
    output logic              m_motor_forward,
    output logic              m_motor_reverse,
    output logic [15:0]       m_motor_compare,
    output logic signed [8:0] m_requested_value
);

    // stage 1 registers
    logic              p1_valid_reg, p1_valid_next;
    cmd_kind_t         p1_kind_reg;
    logic signed [8:0] p1_req_reg;
    logic              p1_fwd_reg;
    logic              p1_rev_reg;
    logic [22:0]       p1_prod_reg;

    // result registers
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg;
    logic [15:0]       out_scmp_reg;
    logic              out_fwd_reg;
    logic              out_rev_reg;
    logic [15:0]       out_mcmp_reg;
    logic signed [8:0] out_req_reg;

    logic              out_adv;
    logic [7:0]        angle_clamped;
    logic [7:0]        speed_mag;
    logic [7:0]        mul_a;
    logic [14:0]       mul_b;
    logic signed [8:0] req_s1;
    logic              fwd_s1;
    logic              rev_s1;
    logic [24:0]       recip;
    logic [47:0]       quot_wide;
    logic [15:0]       quot;

    assign out_adv  = !out_valid_reg || m_ready;
    assign in_ready = !p1_valid_reg || out_adv;

    assign angle_clamped = (cmd.value > ANGLE_MAX) ? ANGLE_MAX : cmd.value;
    assign speed_mag     = cmd.value[7] ? 8'(8'd0 - cmd.value) : cmd.value;

    always_comb begin
        mul_a  = '0;
        mul_b  = cfg.motor_full;
        req_s1 = '0;
        fwd_s1 = 1'b0;
        rev_s1 = 1'b0;
        unique case (cmd.kind)
            KIND_SERVO: begin
                mul_a  = angle_clamped;
                mul_b  = cfg.servo_span;
                req_s1 = $signed({1'b0, cmd.value});
            end
            KIND_MOTOR: begin
                mul_a  = speed_mag;
                req_s1 = $signed({cmd.value[7], cmd.value});
                fwd_s1 = !cmd.value[7] && (cmd.value != 8'd0);
                rev_s1 = cmd.value[7];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (cmd_valid) begin
            p1_valid_next = 1'b1;
        end else if (out_adv) begin
            p1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_adv) begin
            out_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_valid) begin
            p1_kind_reg <= cmd.kind;
            p1_req_reg  <= req_s1;
            p1_fwd_reg  <= fwd_s1;
            p1_rev_reg  <= rev_s1;
            p1_prod_reg <= 23'(mul_a) * 23'(mul_b);
        end
    end

    // divide by 180 or 100 through a reciprocal multiply
    assign recip     = (p1_kind_reg == KIND_SERVO) ? RECIP_DIV180 : RECIP_DIV100;
    assign quot_wide = 48'(p1_prod_reg) * 48'(recip);
    assign quot      = quot_wide[RECIP_SHIFT+15:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && out_adv) begin
            out_kind_reg <= p1_kind_reg;
            out_req_reg  <= p1_req_reg;
            out_fwd_reg  <= p1_fwd_reg;
            out_rev_reg  <= p1_rev_reg;
            out_scmp_reg <= (p1_kind_reg == KIND_SERVO) ?
                            16'(cfg.servo_min) + quot : 16'd0;
            out_mcmp_reg <= (p1_kind_reg == KIND_MOTOR) ? quot : 16'd0;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_cmd_kind        = out_kind_reg;
    assign m_servo_compare   = out_scmp_reg;
    assign m_motor_forward   = out_fwd_reg;
    assign m_motor_reverse   = out_rev_reg;
    assign m_motor_compare   = out_mcmp_reg;
    assign m_requested_value = out_req_reg;

endmodule
